// ===== src/itpt_pkg.sv =====
// Shared types, constants and helpers for the integer-to-text formatter.
// Used by the front, the descriptor queue, the back and the top level.
package itpt_pkg;

    localparam int VALUE_W     = 32;
    localparam int BASE_W      = 6;
    localparam int FLD_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int DIGIT_DEPTH = 32;
    localparam int MAX_WIDTH   = 48;
    localparam int MIN_BASE    = 2;
    localparam int MAX_BASE    = 32;
    localparam int BASE_OCT    = 8;
    localparam int BASE_HEX    = 16;

    localparam int BYTE_W      = 8;
    localparam int NUM_BYTES   = VALUE_W / BYTE_W;
    localparam int BYTE_IDX_W  = $clog2(NUM_BYTES);
    localparam int REM_W       = $clog2(MAX_BASE);
    localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
    localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
    localparam int RAM_DEPTH   = 2 * DIGIT_DEPTH;
    localparam int RAM_AW      = ADDR_W + 1;
    localparam int LEN_W       = $clog2(MAX_WIDTH + DIGIT_DEPTH + 4);
    localparam int PRE_W       = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam int                DEC_DIGS = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
        logic [FLD_W-1:0]   width;
        logic [FLD_W-1:0]   precision;
        logic               left_align;
        logic               zero_pad;
        logic               force_plus;
        logic               space_sign;
        logic               alt_prefix;
        logic               lower_case;
        logic               signed_value;
    } fmt_item_t;

    // One formatted field, ready to be emitted from a digit bank
    typedef struct packed {
        logic               bank;
        logic [LEN_W-1:0]   lead;
        logic               has_sign;
        logic [CHAR_W-1:0]  sign_char;
        logic [PRE_W-1:0]   pre_len;
        logic               pre_hex;
        logic               lower;
        logic [LEN_W-1:0]   zfill;
        logic [LEN_W-1:0]   pzero;
        logic [CNT_W-1:0]   digits;
        logic [LEN_W-1:0]   trail;
        logic [LEN_W-1:0]   total;
    } fmt_desc_t;

    typedef struct packed {
        logic               not_empty;
        logic [Q_CNT_W-1:0] level;
    } q_status_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [DIGIT_W-1:0] data;
    } ram_wr_t;

    function automatic logic [CHAR_W-1:0] digit_char(logic [REM_W-1:0] d, logic lower);
        logic [CHAR_W-1:0] c;
        if (CHAR_W'(d) < CHAR_W'(DEC_DIGS))
            c = CH_ZERO + CHAR_W'(d);
        else
            c = (lower ? CH_LOWER : CH_UPPER) + CHAR_W'(d) - CHAR_W'(DEC_DIGS);
        return c;
    endfunction

    // Index of the highest nonzero byte, zero when the word is zero
    function automatic logic [BYTE_IDX_W-1:0] top_byte(logic [VALUE_W-1:0] v);
        logic [BYTE_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (v[i*BYTE_W +: BYTE_W] != '0)
                idx = BYTE_IDX_W'(i);
        end
        return idx;
    endfunction

endpackage

// ===== src/itpt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module itpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/itpt_queue.sv =====
// Short descriptor queue between front and back; head is read in place and
// popped only when its field is fully emitted. Depends on itpt_pkg.
module itpt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  itpt_pkg::fmt_desc_t push_desc,
    input  logic                pop,
    output itpt_pkg::fmt_desc_t head,
    output itpt_pkg::q_status_t status
);
    import itpt_pkg::*;

    fmt_desc_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.level     = count_reg;

endmodule

// ===== src/itpt_front.sv =====
// Front: accepts an item, classifies sign and prefix, converts the magnitude
// into digits (one byte of long division per cycle) into a RAM bank, then
// queues a field descriptor. Depends on itpt_pkg.
module itpt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itpt_pkg::fmt_item_t  in_item,
    input  itpt_pkg::q_status_t  q_status,
    output logic                 q_push,
    output itpt_pkg::fmt_desc_t  q_desc,
    output itpt_pkg::ram_wr_t    ram_wr
);
    import itpt_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]     dvd_reg, dvd_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [BYTE_IDX_W-1:0]  byte_reg, byte_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   bank_reg, bank_next;
    logic [BASE_W-1:0]      base_reg;
    logic [FLD_W-1:0]       fw_reg;
    logic [FLD_W-1:0]       prec_reg;
    logic                   has_sign_reg;
    logic [CHAR_W-1:0]      sign_char_reg;
    logic [PRE_W-1:0]       pre_len_reg;
    logic                   pre_hex_reg;
    logic                   left_reg;
    logic                   zpad_reg;
    logic                   lower_reg;

    logic                   accept;
    logic                   base_ok;
    logic                   neg;
    logic [VALUE_W-1:0]     mag;

    logic [BYTE_W-1:0]      cur_byte;
    logic [BYTE_W-1:0]      q_byte;
    logic [REM_W-1:0]       r;
    logic [BASE_W-1:0]      t;
    logic [VALUE_W-1:0]     dvd_upd;
    logic [CNT_W-1:0]       cnt_inc;

    logic [LEN_W-1:0]       cnt_l;
    logic [LEN_W-1:0]       prec_l;
    logic [LEN_W-1:0]       fw_l;
    logic [LEN_W-1:0]       prec_eff;
    logic [LEN_W-1:0]       need;
    logic [LEN_W-1:0]       pad;

    assign in_ready = (state_reg == F_IDLE) && (q_status.level < Q_CNT_W'(Q_DEPTH));
    assign accept   = in_valid && in_ready;
    assign base_ok  = (in_item.base >= BASE_W'(MIN_BASE)) && (in_item.base <= BASE_W'(MAX_BASE));
    assign neg      = in_item.signed_value && in_item.value[VALUE_W-1];
    assign mag      = neg ? (VALUE_W'(0) - in_item.value) : in_item.value;

    // One byte of restoring division by the radix, MSB first
    always_comb
    begin
        cur_byte = dvd_reg[byte_reg*BYTE_W +: BYTE_W];
        r        = rem_reg;
        q_byte   = '0;
        t        = '0;
        for (int j = BYTE_W - 1; j >= 0; j--)
        begin
            t = BASE_W'({r, cur_byte[j]});
            if (t >= base_reg)
            begin
                q_byte[j] = 1'b1;
                t         = t - base_reg;
            end
            r = t[REM_W-1:0];
        end
        dvd_upd = dvd_reg;
        dvd_upd[byte_reg*BYTE_W +: BYTE_W] = q_byte;
    end

    assign cnt_inc = cnt_reg + CNT_W'(1);

    // Field layout once the digit count is known
    always_comb
    begin
        cnt_l    = LEN_W'(cnt_reg);
        prec_l   = LEN_W'(prec_reg);
        fw_l     = LEN_W'(fw_reg);
        prec_eff = (prec_l > cnt_l) ? prec_l : cnt_l;
        need     = prec_eff + LEN_W'(has_sign_reg) + LEN_W'(pre_len_reg);
        pad      = (fw_l > need) ? (fw_l - need) : '0;

        q_desc.bank      = bank_reg;
        q_desc.lead      = (!left_reg && !zpad_reg) ? pad : '0;
        q_desc.has_sign  = has_sign_reg;
        q_desc.sign_char = sign_char_reg;
        q_desc.pre_len   = pre_len_reg;
        q_desc.pre_hex   = pre_hex_reg;
        q_desc.lower     = lower_reg;
        q_desc.zfill     = zpad_reg ? pad : '0;
        q_desc.pzero     = prec_eff - cnt_l;
        q_desc.digits    = cnt_reg;
        q_desc.trail     = left_reg ? pad : '0;
        q_desc.total     = need + pad;
    end

    always_comb
    begin
        state_next  = state_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        byte_next   = byte_reg;
        cnt_next    = cnt_reg;
        bank_next   = bank_reg;
        q_push      = 1'b0;
        ram_wr.we   = 1'b0;
        ram_wr.addr = {bank_reg, cnt_reg[ADDR_W-1:0]};
        ram_wr.data = DIGIT_W'(r);
        unique case (state_reg)
            F_IDLE:
            begin
                // drop items with a radix out of range
                if (accept && base_ok)
                begin
                    dvd_next   = mag;
                    rem_next   = '0;
                    byte_next  = top_byte(mag);
                    cnt_next   = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                dvd_next = dvd_upd;
                if (byte_reg == '0)
                begin
                    ram_wr.we = 1'b1;
                    cnt_next  = cnt_inc;
                    rem_next  = '0;
                    byte_next = top_byte(dvd_upd);
                    if (dvd_upd == '0 || cnt_inc == CNT_W'(DIGIT_DEPTH))
                        state_next = F_PUSH;
                end
                else
                begin
                    byte_next = byte_reg - BYTE_IDX_W'(1);
                    rem_next  = r;
                end
            end
            F_PUSH:
            begin
                q_push     = 1'b1;
                bank_next  = !bank_reg;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            bank_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        byte_reg <= byte_next;
        if (accept)
        begin
            base_reg      <= in_item.base;
            fw_reg        <= (in_item.width > FLD_W'(MAX_WIDTH)) ?
                             FLD_W'(MAX_WIDTH) : in_item.width;
            prec_reg      <= (in_item.precision > FLD_W'(MAX_WIDTH)) ?
                             FLD_W'(MAX_WIDTH) : in_item.precision;
            has_sign_reg  <= neg || in_item.force_plus || in_item.space_sign;
            sign_char_reg <= neg ? CH_MINUS : (in_item.force_plus ? CH_PLUS : CH_SPACE);
            pre_hex_reg   <= (in_item.base == BASE_W'(BASE_HEX));
            if (in_item.alt_prefix && in_item.base == BASE_W'(BASE_HEX))
                pre_len_reg <= PRE_W'(2);
            else if (in_item.alt_prefix && in_item.base == BASE_W'(BASE_OCT))
                pre_len_reg <= PRE_W'(1);
            else
                pre_len_reg <= '0;
            left_reg      <= in_item.left_align;
            zpad_reg      <= in_item.zero_pad && !in_item.left_align;
            lower_reg     <= in_item.lower_case;
        end
    end

endmodule

// ===== src/itpt_back.sv =====
// Back: walks the head descriptor and emits one character per transfer
// through an output register, reading digits most significant first.
// Depends on itpt_pkg.
module itpt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  itpt_pkg::fmt_desc_t         head,
    input  itpt_pkg::q_status_t         q_status,
    output logic                        q_pop,
    output logic [itpt_pkg::RAM_AW-1:0] ram_raddr,
    input  logic [itpt_pkg::DIGIT_W-1:0] ram_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [itpt_pkg::CHAR_W-1:0] out_char,
    output logic                        last
);
    import itpt_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EMIT = 2'b10
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [LEN_W-1:0]   lead_reg, lead_next;
    logic               sign_reg, sign_next;
    logic [CHAR_W-1:0]  sign_char_reg, sign_char_next;
    logic [PRE_W-1:0]   pre_reg, pre_next;
    logic               pre_hex_reg, pre_hex_next;
    logic               lower_reg, lower_next;
    logic [LEN_W-1:0]   zfill_reg, zfill_next;
    logic [LEN_W-1:0]   pzero_reg, pzero_next;
    logic [CNT_W-1:0]   dig_reg, dig_next;
    logic [LEN_W-1:0]   trail_reg, trail_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               last_reg, last_next;

    logic               advance;
    logic [CNT_W-1:0]   dig_m1;
    logic [CHAR_W-1:0]  ch;

    assign advance = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        lead_next      = lead_reg;
        sign_next      = sign_reg;
        sign_char_next = sign_char_reg;
        pre_next       = pre_reg;
        pre_hex_next   = pre_hex_reg;
        lower_next     = lower_reg;
        zfill_next     = zfill_reg;
        pzero_next     = pzero_reg;
        dig_next       = dig_reg;
        trail_next     = trail_reg;
        total_next     = total_reg;
        q_pop          = 1'b0;
        ch             = CH_SPACE;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    bank_next      = head.bank;
                    lead_next      = head.lead;
                    sign_next      = head.has_sign;
                    sign_char_next = head.sign_char;
                    pre_next       = head.pre_len;
                    pre_hex_next   = head.pre_hex;
                    lower_next     = head.lower;
                    zfill_next     = head.zfill;
                    pzero_next     = head.pzero;
                    dig_next       = head.digits;
                    trail_next     = head.trail;
                    total_next     = head.total;
                    state_next     = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (advance)
                begin
                    priority if (lead_reg != '0)
                    begin
                        ch        = CH_SPACE;
                        lead_next = lead_reg - LEN_W'(1);
                    end
                    else if (sign_reg)
                    begin
                        ch        = sign_char_reg;
                        sign_next = 1'b0;
                    end
                    else if (pre_reg != '0)
                    begin
                        ch       = (pre_reg == PRE_W'(1) && pre_hex_reg) ?
                                   (lower_reg ? CH_X_LO : CH_X_UP) : CH_ZERO;
                        pre_next = pre_reg - PRE_W'(1);
                    end
                    else if (zfill_reg != '0)
                    begin
                        ch         = CH_ZERO;
                        zfill_next = zfill_reg - LEN_W'(1);
                    end
                    else if (pzero_reg != '0)
                    begin
                        ch         = CH_ZERO;
                        pzero_next = pzero_reg - LEN_W'(1);
                    end
                    else if (dig_reg != '0)
                    begin
                        ch       = digit_char(ram_rdata[REM_W-1:0], lower_reg);
                        dig_next = dig_reg - CNT_W'(1);
                    end
                    else
                    begin
                        ch         = CH_SPACE;
                        trail_next = trail_reg - LEN_W'(1);
                    end
                    total_next = total_reg - LEN_W'(1);
                    if (total_reg == LEN_W'(1))
                    begin
                        q_pop      = 1'b1;
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hold the output register until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ch;
            last_next      = (total_reg == LEN_W'(1));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Address from next-state values so the registered read lines up with dig_reg
    assign dig_m1    = dig_next - CNT_W'(1);
    assign ram_raddr = {bank_next, dig_m1[ADDR_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            bank_reg      <= 1'b0;
            lead_reg      <= '0;
            sign_reg      <= 1'b0;
            pre_reg       <= '0;
            zfill_reg     <= '0;
            pzero_reg     <= '0;
            dig_reg       <= '0;
            trail_reg     <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bank_reg      <= bank_next;
            lead_reg      <= lead_next;
            sign_reg      <= sign_next;
            pre_reg       <= pre_next;
            zfill_reg     <= zfill_next;
            pzero_reg     <= pzero_next;
            dig_reg       <= dig_next;
            trail_reg     <= trail_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_char_reg <= sign_char_next;
        pre_hex_reg   <= pre_hex_next;
        lower_reg     <= lower_next;
        out_char_reg  <= out_char_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// ===== src/integer_to_padded_text.sv =====
// Top level of the printf-style integer formatter: front, descriptor queue,
// two-bank digit RAM and back. Depends on itpt_pkg and all itpt_* modules.
//
//   channel  dir  handshake            payload
//   -------  ---  -------------------  --------------------------------------
//   in       in   in_valid/in_ready    value base width precision + 7 flags
//   out      out  out_valid/out_ready  out_char last
//
// Front: for each digit, one step of byte-wide division by the radix per
// byte of the dividend from its highest nonzero byte down; a push state
// then queues the descriptor. Back: a load state, then one character per
// cycle unless the output stalls, up to 51 characters per field.
// The two digit banks let conversion of one item overlap emission of the last.
// A radix outside 2..32 is accepted and dropped. Reset clears all control;
// a stalled output holds its character and the back stops behind it.
module integer_to_padded_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    input  logic [5:0]  base,
    input  logic [5:0]  width,
    input  logic [5:0]  precision,
    input  logic        left_align,
    input  logic        zero_pad,
    input  logic        force_plus,
    input  logic        space_sign,
    input  logic        alt_prefix,
    input  logic        lower_case,
    input  logic        signed_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);
    import itpt_pkg::*;

    fmt_item_t          item;
    q_status_t          q_status;
    logic               q_push;
    logic               q_pop;
    fmt_desc_t          q_desc;
    fmt_desc_t          q_head;
    ram_wr_t            ram_wr;
    logic [RAM_AW-1:0]  ram_raddr;
    logic [DIGIT_W-1:0] ram_rdata;

    always_comb
    begin
        item.value        = value;
        item.base         = base;
        item.width        = width;
        item.precision    = precision;
        item.left_align   = left_align;
        item.zero_pad     = zero_pad;
        item.force_plus   = force_plus;
        item.space_sign   = space_sign;
        item.alt_prefix   = alt_prefix;
        item.lower_case   = lower_case;
        item.signed_value = signed_value;
    end

    itpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (item),
        .q_status (q_status),
        .q_push   (q_push),
        .q_desc   (q_desc),
        .ram_wr   (ram_wr)
    );

    itpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    itpt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (RAM_DEPTH)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (ram_wr.we),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    itpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

// ===== sim/integer_to_padded_text_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_padded_text: a queue-fed driver and
// a monitor that predicts every formatted field. Depends on itpt_pkg and the RTL.
module integer_to_padded_text_tb;
    import itpt_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 450;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 600;
    localparam int REPORT_LIMIT   = 10;

    // Flag bit positions, in the order of the item fields
    localparam logic [6:0] F_LEFT  = 7'b1000000;
    localparam logic [6:0] F_ZERO  = 7'b0100000;
    localparam logic [6:0] F_PLUS  = 7'b0010000;
    localparam logic [6:0] F_SPACE = 7'b0001000;
    localparam logic [6:0] F_ALT   = 7'b0000100;
    localparam logic [6:0] F_LOWER = 7'b0000010;
    localparam logic [6:0] F_SIGN  = 7'b0000001;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              lst;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] value = '0;
    logic [5:0]  base = '0;
    logic [5:0]  width = '0;
    logic [5:0]  precision = '0;
    logic        left_align = 1'b0;
    logic        zero_pad = 1'b0;
    logic        force_plus = 1'b0;
    logic        space_sign = 1'b0;
    logic        alt_prefix = 1'b0;
    logic        lower_case = 1'b0;
    logic        signed_value = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        last;

    fmt_item_t  pending_items[$];
    text_char_t expected_chars[$];
    fmt_item_t  offered;

    int sent_count = 0;
    int items_in = 0;
    int items_dropped = 0;
    int chars_out = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;

    assign offered = {value, base, width, precision, left_align, zero_pad, force_plus,
                      space_sign, alt_prefix, lower_case, signed_value};

    integer_to_padded_text DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .value(value), .base(base), .width(width), .precision(precision),
        .left_align(left_align), .zero_pad(zero_pad), .force_plus(force_plus),
        .space_sign(space_sign), .alt_prefix(alt_prefix), .lower_case(lower_case),
        .signed_value(signed_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_char(out_char), .last(last)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic bit no_idle(int count);
        return (count >= 120 && count < 180) || (count >= 380 && count < 410);
    endfunction

    function automatic fmt_item_t make_item(logic [31:0] v, logic [5:0] b, logic [5:0] w,
                                            logic [5:0] p, logic [6:0] flags);
        return {v, b, w, p, flags};
    endfunction

    function automatic logic [7:0] digit_glyph(int d, bit lower);
        if (d < 10)
            return 8'("0") + 8'(d);
        return (lower ? 8'("a") : 8'("A")) + 8'(d - 10);
    endfunction

    // Queue the characters of one formatted field
    function automatic void format_field(fmt_item_t it);
        logic [31:0] mag;
        logic [7:0]  sign_ch;
        logic [7:0]  line[$];
        int          digs[DIGIT_DEPTH];
        int          fw, prec, cnt, size, radix;
        bit          left, zpad, alt8, alt16, lower;
        text_char_t  tc;

        radix = int'(it.base);
        if (radix < MIN_BASE || radix > MAX_BASE)
            return;
        fw    = (int'(it.width) > MAX_WIDTH) ? MAX_WIDTH : int'(it.width);
        prec  = (int'(it.precision) > MAX_WIDTH) ? MAX_WIDTH : int'(it.precision);
        left  = it.left_align;
        zpad  = it.zero_pad && !left;
        lower = it.lower_case;
        alt8  = it.alt_prefix && radix == BASE_OCT;
        alt16 = it.alt_prefix && radix == BASE_HEX;
        mag   = it.value;
        sign_ch = 8'h00;
        if (it.signed_value && mag[31]) begin
            sign_ch = 8'("-");
            mag = 32'd0 - mag;
        end
        else if (it.force_plus)
            sign_ch = 8'("+");
        else if (it.space_sign)
            sign_ch = 8'(" ");

        size = fw - ((sign_ch != 8'h00) ? 1 : 0) - (alt16 ? 2 : (alt8 ? 1 : 0));
        cnt = 0;
        if (mag == 32'd0) begin
            digs[0] = 0;
            cnt = 1;
        end
        else begin
            while (mag != 32'd0 && cnt < DIGIT_DEPTH) begin
                digs[cnt] = int'(mag % 32'(radix));
                mag = mag / 32'(radix);
                cnt++;
            end
        end
        if (prec < cnt)
            prec = cnt;
        size -= prec;

        if (!zpad && !left)
            for (; size > 0; size--)
                line.push_back(8'(" "));
        if (sign_ch != 8'h00)
            line.push_back(sign_ch);
        if (alt8 || alt16)
            line.push_back(8'("0"));
        if (alt16)
            line.push_back(lower ? 8'("x") : 8'("X"));
        if (!left)
            for (; size > 0; size--)
                line.push_back(zpad ? 8'("0") : 8'(" "));
        for (int i = prec; i > cnt; i--)
            line.push_back(8'("0"));
        for (int i = cnt - 1; i >= 0; i--)
            line.push_back(digit_glyph(digs[i], lower));
        for (; size > 0; size--)
            line.push_back(8'(" "));

        foreach (line[i]) begin
            tc.ch  = line[i];
            tc.lst = (i == line.size() - 1);
            expected_chars.push_back(tc);
        end
    endfunction

    function automatic fmt_item_t random_item();
        logic [31:0] v;
        logic [5:0]  b, w, p;
        int          r;

        r = $urandom_range(0, 99);
        if (r < 40)
            v = $urandom;
        else if (r < 60)
            v = $urandom_range(0, 1000);
        else if (r < 75) begin
            case ($urandom_range(0, 4))
                0: v = 32'h0000_0000;
                1: v = 32'h0000_0001;
                2: v = 32'hFFFF_FFFF;
                3: v = 32'h8000_0000;
                default: v = 32'h7FFF_FFFF;
            endcase
        end
        else
            v = $urandom >> $urandom_range(0, 31);

        r = $urandom_range(0, 99);
        if (r < 25)
            b = 6'd10;
        else if (r < 40)
            b = 6'(BASE_HEX);
        else if (r < 50)
            b = 6'(BASE_OCT);
        else if (r < 58)
            b = 6'd2;
        else if (r < 95)
            b = 6'($urandom_range(MIN_BASE, MAX_BASE));
        else if (r < 97)
            b = 6'($urandom_range(0, MIN_BASE - 1));
        else
            b = 6'($urandom_range(MAX_BASE + 1, 63));

        r = $urandom_range(0, 99);
        if (r < 80)
            w = 6'($urandom_range(0, 20));
        else if (r < 95)
            w = 6'($urandom_range(0, MAX_WIDTH));
        else
            w = 6'($urandom_range(MAX_WIDTH + 1, 63));

        r = $urandom_range(0, 99);
        if (r < 50)
            p = 6'd0;
        else if (r < 85)
            p = 6'($urandom_range(1, 12));
        else if (r < 95)
            p = 6'($urandom_range(0, MAX_WIDTH));
        else
            p = 6'($urandom_range(MAX_WIDTH + 1, 63));

        return make_item(v, b, w, p, 7'($urandom_range(0, 127)));
    endfunction

    // Driver: offer the next pending item, hold it until the transfer
    always @(posedge clk or negedge rst_n) begin
        fmt_item_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                {value, base, width, precision, left_align, zero_pad, force_plus,
                 space_sign, alt_prefix, lower_case, signed_value} <= nxt;
                in_valid <= 1'b1;
                send_gap <= no_idle(sent_count) ? 0 : pick_gap();
                sent_count <= sent_count + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus two long hold-offs that back up the input
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done < 2 && items_in >= (holds_done == 0 ? 40 : 260)) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_idle(items_in) && $urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge clk) begin
        text_char_t want;
        int         queued;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                queued = expected_chars.size();
                format_field(offered);
                if (expected_chars.size() == queued)
                    items_dropped <= items_dropped + 1;
                items_in <= items_in + 1;
            end
            if (out_valid && out_ready) begin
                chars_out <= chars_out + 1;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] unexpected char: out_char=%h last=%b",
                                 $realtime, out_char, last);
                end
                else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== out_char || want.lst !== last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("[%0t] char %0d: expected out_char=%h last=%b, got %h %b",
                                     $realtime, chars_out, want.ch, want.lst, out_char, last);
                    end
                end
            end
        end
    end

    // Watchdog: stop when no transfer happens on either side for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        // Directed items: extremes, every flag, bad radix, saturation
        pending_items.push_back(make_item(32'd0, 6'd10, 6'd0, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'd0, 6'(BASE_OCT), 6'd0, 6'd0, F_ALT));
        pending_items.push_back(make_item(32'd0, 6'(BASE_HEX), 6'd8, 6'd0, F_ALT | F_ZERO));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 6'd10, 6'd0, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 6'd10, 6'd0, 6'd0, F_SIGN));
        pending_items.push_back(make_item(32'h8000_0000, 6'd10, 6'd15, 6'd0, F_SIGN));
        pending_items.push_back(make_item(32'h7FFF_FFFF, 6'd10, 6'd0, 6'd0, F_SIGN | F_PLUS));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 6'd2, 6'd0, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 6'(MAX_BASE), 6'd0, 6'd0, F_LOWER));
        pending_items.push_back(make_item(32'hDEAD_BEEF, 6'(BASE_HEX), 6'd12, 6'd0,
                                          F_ALT | F_LOWER | F_ZERO));
        pending_items.push_back(make_item(32'hDEAD_BEEF, 6'(BASE_HEX), 6'd12, 6'd0,
                                          F_ALT | F_LEFT));
        pending_items.push_back(make_item(32'o777, 6'(BASE_OCT), 6'd6, 6'd0, F_ALT));
        pending_items.push_back(make_item(32'd1234, 6'd10, 6'd0, 6'd0, F_ALT));
        pending_items.push_back(make_item(32'd42, 6'd10, 6'd10, 6'd0, F_LEFT | F_ZERO));
        pending_items.push_back(make_item(32'd42, 6'd10, 6'd10, 6'd0, F_PLUS | F_ZERO));
        pending_items.push_back(make_item(32'd42, 6'd10, 6'd6, 6'd0, F_SPACE));
        pending_items.push_back(make_item(32'd123456, 6'd10, 6'd3, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'd7, 6'd10, 6'd4, 6'd9, 7'b0));
        pending_items.push_back(make_item(32'hFFFF_FFF6, 6'd10, 6'd63, 6'd63,
                                          F_SIGN | F_ZERO));
        pending_items.push_back(make_item(32'd99, 6'd10, 6'd63, 6'd5, F_LEFT | F_PLUS));
        pending_items.push_back(make_item(32'd99, 6'd0, 6'd5, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'd99, 6'd1, 6'd5, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'd99, 6'(MAX_BASE + 1), 6'd5, 6'd0, 7'b0));
        pending_items.push_back(make_item(32'd99, 6'd63, 6'd5, 6'd0, 7'b1111111));
        pending_items.push_back(make_item(32'd35, 6'd36 - 6'd4, 6'd0, 6'd0, 7'b0));
        repeat (RANDOM_ITEMS)
            pending_items.push_back(random_item());

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        // let the design run on; the monitor flags any extra characters
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0) begin
            mismatches++;
            $display("%0d expected chars never arrived", expected_chars.size());
        end

        $display("Formatted %0d items (%0d with bad radix dropped), %0d chars checked,",
                 items_in, items_dropped, chars_out);
        $display("with random gaps on both sides and %0d long output hold-offs.", holds_done);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
